// ===== rtl/goldilocks_field_alu_unit_macros.svh =====
// Assertion macros for the Goldilocks field ALU checker.
// Depends on nothing; taken in by the checker with `include.
`ifndef GOLDILOCKS_FIELD_ALU_UNIT_MACROS_SVH
`define GOLDILOCKS_FIELD_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/glf_pkg.sv =====
// Shared types, constants and helper functions for the Goldilocks field ALU.
// Used by glf_mul and goldilocks_field_alu_unit; depends on nothing.
package glf_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  // 2^64 mod p, also -p mod 2^64
  localparam logic [WordW-1:0] Eps = 64'h0000_0000_ffff_ffff;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_SUB = 2'd1,
    REQ_MUL = 2'd2,
    REQ_POW = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_OP0,
    S_OP1,
    S_OP2,
    S_MUL_WAIT,
    S_POW_INIT,
    S_POW_LOOP,
    S_POW_SQ,
    S_POW_MUL
  } top_state_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_RED,
    M_PROD,
    M_SUB_HI,
    M_FIX_BORROW,
    M_MAKE_T,
    M_ADD_T,
    M_FIX_CARRY
  } mul_state_e;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } mul_rsp_t;

  // x + y or x - y; bit 64 is the carry out (for a subtract: no borrow)
  function automatic logic [WordW:0] add_sub(input logic [WordW-1:0] x,
                                             input logic [WordW-1:0] y,
                                             input logic             sub);
    logic [WordW-1:0] yy;
    yy = sub ? ~y : y;
    return {1'b0, x} + {1'b0, yy} + {{WordW{1'b0}}, sub};
  endfunction

  // v mod p: v >= p exactly when v + Eps carries, and then v - p = v + Eps
  function automatic logic [WordW-1:0] reduce_p(input logic [WordW-1:0] v);
    logic [WordW:0] s;
    s = {1'b0, v} + {1'b0, Eps};
    return s[WordW] ? s[WordW-1:0] : v;
  endfunction

endpackage

// ===== rtl/goldilocks_field_alu_unit.sv =====
// Goldilocks field ALU: add, subtract, multiply and power mod 2^64 - 2^32 + 1.
// Depends on glf_pkg and glf_mul.
//
// Usage: drive req_type_i, operand_a_i and operand_b_i and raise start; the item
// is taken at the clock edge where start is high and busy is low. busy stays
// high while the item is worked on. The result shows on result_o for exactly
// one cycle with done_o high, and busy is already low in that cycle, so the
// next item may be started at once. result_o may be non-canonical (not below p).
// Every modular multiply runs on the one shared glf_mul unit: take, operand
// reduction, the partial products and their accumulation, then five adder steps.
// A power with a zero exponent or a zero base ends without any multiply. One
// item at a time; the next item is taken at the edge that ends the done_o cycle.
// Reset returns the block to idle with done_o low; an item in flight is dropped.
// The receiver cannot stall: a result is shown once and not held back.
module goldilocks_field_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  localparam int unsigned W = glf_pkg::WordW;

  glf_pkg::top_state_e state_q, state_d;
  glf_pkg::req_type_e  op_q, op_d;

  logic [W-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [W-1:0] result_q, result_d;
  logic         flag_q, flag_d;
  logic         done_q, done_d;

  logic [W-1:0] add_x, add_y;
  logic         add_sub;
  logic [W:0]   add_res;
  logic         is_sub;

  glf_pkg::mul_req_t mul_req;
  glf_pkg::mul_rsp_t mul_rsp;

  glf_mul u_glf_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign is_sub  = (op_q == glf_pkg::REQ_SUB);
  assign add_res = glf_pkg::add_sub(add_x, add_y, add_sub);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    a_d           = a_q;
    b_d           = b_q;
    r_d           = r_q;
    flag_d        = flag_q;
    result_d      = result_q;
    done_d        = 1'b0;
    add_x         = r_q;
    add_y         = flag_q ? glf_pkg::Eps : '0;
    add_sub       = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = a_q;
    mul_req.y     = b_q;
    unique case (state_q)
      glf_pkg::S_IDLE: begin
        if (start) begin
          op_d    = glf_pkg::req_type_e'(req_type_i);
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          state_d = glf_pkg::S_RED;
        end
      end
      glf_pkg::S_RED: begin
        a_d = glf_pkg::reduce_p(a_q);
        // the power exponent stays raw
        if (op_q != glf_pkg::REQ_POW) begin
          b_d = glf_pkg::reduce_p(b_q);
        end
        unique case (op_q)
          glf_pkg::REQ_ADD,
          glf_pkg::REQ_SUB: state_d = glf_pkg::S_OP0;
          glf_pkg::REQ_MUL: begin
            mul_req.start = 1'b1;
            state_d       = glf_pkg::S_MUL_WAIT;
          end
          default:          state_d = glf_pkg::S_POW_INIT;
        endcase
      end
      glf_pkg::S_OP0: begin
        add_x   = a_q;
        add_y   = b_q;
        add_sub = is_sub;
        r_d     = add_res[W-1:0];
        flag_d  = is_sub ? ~add_res[W] : add_res[W];
        state_d = glf_pkg::S_OP1;
      end
      glf_pkg::S_OP1: begin
        add_sub = is_sub;
        r_d     = add_res[W-1:0];
        flag_d  = is_sub ? ~add_res[W] : add_res[W];
        state_d = glf_pkg::S_OP2;
      end
      glf_pkg::S_OP2: begin
        // final correction always adds
        result_d = add_res[W-1:0];
        done_d   = 1'b1;
        state_d  = glf_pkg::S_IDLE;
      end
      glf_pkg::S_MUL_WAIT: begin
        if (mul_rsp.done) begin
          result_d = mul_rsp.res;
          done_d   = 1'b1;
          state_d  = glf_pkg::S_IDLE;
        end
      end
      glf_pkg::S_POW_INIT: begin
        if (b_q == '0) begin
          result_d = {{(W-1){1'b0}}, 1'b1};
          done_d   = 1'b1;
          state_d  = glf_pkg::S_IDLE;
        end else if (a_q == '0) begin
          result_d = '0;
          done_d   = 1'b1;
          state_d  = glf_pkg::S_IDLE;
        end else begin
          r_d     = b_q[0] ? a_q : {{(W-1){1'b0}}, 1'b1};
          b_d     = b_q >> 1;
          state_d = glf_pkg::S_POW_LOOP;
        end
      end
      glf_pkg::S_POW_LOOP: begin
        // b_q holds the exponent bits not yet consumed
        if (b_q == '0) begin
          result_d = r_q;
          done_d   = 1'b1;
          state_d  = glf_pkg::S_IDLE;
        end else begin
          mul_req.start = 1'b1;
          mul_req.x     = a_q;
          mul_req.y     = a_q;
          state_d       = glf_pkg::S_POW_SQ;
        end
      end
      glf_pkg::S_POW_SQ: begin
        if (mul_rsp.done) begin
          a_d = mul_rsp.res;
          if (b_q[0]) begin
            mul_req.start = 1'b1;
            mul_req.x     = r_q;
            mul_req.y     = mul_rsp.res;
            state_d       = glf_pkg::S_POW_MUL;
          end else begin
            b_d     = b_q >> 1;
            state_d = glf_pkg::S_POW_LOOP;
          end
        end
      end
      glf_pkg::S_POW_MUL: begin
        if (mul_rsp.done) begin
          r_d     = mul_rsp.res;
          b_d     = b_q >> 1;
          state_d = glf_pkg::S_POW_LOOP;
        end
      end
      default: begin
        state_d = glf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glf_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    flag_q   <= flag_d;
    result_q <= result_d;
  end

  assign busy     = (state_q != glf_pkg::S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/glf_mul.sv =====
// Iterative modular multiplier mod 2^64 - 2^32 + 1: one 32x32 multiplier, a 128-bit
// accumulator and one 64-bit adder under a small sequencer. Depends on glf_pkg.
module glf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glf_pkg::mul_req_t req_i,
  output glf_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned ProdSteps = 4;
  localparam int unsigned W         = glf_pkg::WordW;
  localparam int unsigned H         = glf_pkg::HalfW;

  glf_pkg::mul_state_e state_q, state_d;

  logic [W-1:0]   a_q, a_d, b_q, b_d, r_q, r_d;
  logic [W-1:0]   pp_q, pp_d;
  logic [2*W-1:0] acc_q, acc_d;
  logic [2:0]     cnt_q, cnt_d;
  logic           flag_q, flag_d;
  logic           done_q, done_d;

  logic [H-1:0]   mx, my, hhi, hlo;
  logic [1:0]     acc_sel;
  logic [2*W-1:0] addend;
  logic [W-1:0]   add_x, add_y;
  logic           add_sub;
  logic [W:0]     add_res;

  assign hhi = acc_q[2*W-1:W+H];
  assign hlo = acc_q[W+H-1:W];

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin mx = a_q[H-1:0]; my = b_q[H-1:0]; end
      2'd1: begin mx = a_q[H-1:0]; my = b_q[W-1:H]; end
      2'd2: begin mx = a_q[W-1:H]; my = b_q[H-1:0]; end
      default: begin mx = a_q[W-1:H]; my = b_q[W-1:H]; end
    endcase
  end

  // Place the previous partial product at its weight
  assign acc_sel = cnt_q[1:0] - 2'd1;
  always_comb begin
    unique case (acc_sel)
      2'd0:    addend = {{W{1'b0}}, pp_q};
      2'd1,
      2'd2:    addend = {{H{1'b0}}, pp_q, {H{1'b0}}};
      default: addend = {pp_q, {W{1'b0}}};
    endcase
  end

  assign add_res = glf_pkg::add_sub(add_x, add_y, add_sub);

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    r_d     = r_q;
    pp_d    = pp_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    flag_d  = flag_q;
    done_d  = 1'b0;
    add_x   = r_q;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      glf_pkg::M_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.x;
          b_d     = req_i.y;
          state_d = glf_pkg::M_RED;
        end
      end
      glf_pkg::M_RED: begin
        a_d     = glf_pkg::reduce_p(a_q);
        b_d     = glf_pkg::reduce_p(b_q);
        cnt_d   = '0;
        state_d = glf_pkg::M_PROD;
      end
      glf_pkg::M_PROD: begin
        pp_d  = {{H{1'b0}}, mx} * {{H{1'b0}}, my};
        acc_d = (cnt_q == '0) ? '0 : acc_q + addend;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(ProdSteps)) begin
          state_d = glf_pkg::M_SUB_HI;
        end
      end
      glf_pkg::M_SUB_HI: begin
        // lo - hi[127:96], since 2^96 = -1
        add_x   = acc_q[W-1:0];
        add_y   = {{H{1'b0}}, hhi};
        add_sub = 1'b1;
        r_d     = add_res[W-1:0];
        flag_d  = ~add_res[W];
        state_d = glf_pkg::M_FIX_BORROW;
      end
      glf_pkg::M_FIX_BORROW: begin
        add_y   = flag_q ? glf_pkg::Eps : '0;
        add_sub = 1'b1;
        r_d     = add_res[W-1:0];
        state_d = glf_pkg::M_MAKE_T;
      end
      glf_pkg::M_MAKE_T: begin
        // hi[95:64] * (2^32 - 1); the reduced operands are no longer needed
        add_x   = {hlo, {H{1'b0}}};
        add_y   = {{H{1'b0}}, hlo};
        add_sub = 1'b1;
        a_d     = add_res[W-1:0];
        state_d = glf_pkg::M_ADD_T;
      end
      glf_pkg::M_ADD_T: begin
        add_y   = a_q;
        r_d     = add_res[W-1:0];
        flag_d  = add_res[W];
        state_d = glf_pkg::M_FIX_CARRY;
      end
      glf_pkg::M_FIX_CARRY: begin
        add_y   = flag_q ? glf_pkg::Eps : '0;
        r_d     = add_res[W-1:0];
        done_d  = 1'b1;
        state_d = glf_pkg::M_IDLE;
      end
      default: begin
        state_d = glf_pkg::M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glf_pkg::M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    r_q    <= r_d;
    pp_q   <= pp_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    flag_q <= flag_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

endmodule

// ===== rtl/glf_checker.sv =====
// Port-level checker for the Goldilocks field ALU, bound to the top level.
// Depends on goldilocks_field_alu_unit_macros.svh.
`include "goldilocks_field_alu_unit_macros.svh"

module glf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `GLF_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted item left block idle")
  `GLF_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result shown while still busy")
  `GLF_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_o, !done_o, "result strobe held for two cycles")
  `GLF_ASSERT_NXT(a_no_early_done, clk_i, rst_ni, start && !busy, !done_o, "result right after accept")

endmodule

bind goldilocks_field_alu_unit glf_checker u_glf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

// ===== tb/goldilocks_field_alu_unit_tb.sv =====
// Self-checking testbench for goldilocks_field_alu_unit: directed edge cases, then random items.
// Predicts every result with its own model of the field arithmetic and checks each done_o strobe.
// Depends on glf_pkg and the RTL of goldilocks_field_alu_unit.
`timescale 1ns / 100ps

module goldilocks_field_alu_unit_tb;

  localparam bit [63:0] FieldP   = 64'hffff_ffff_0000_0001;
  localparam bit [63:0] FoldEps  = 64'h0000_0000_ffff_ffff;
  localparam bit [63:0] AllOnes  = 64'hffff_ffff_ffff_ffff;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned DrainCycles = 20;
  // all items as full-width powers with the longest gaps, taken three times over
  localparam int unsigned CycleLimit  = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [63:0] operand_a_i;
  logic [63:0] operand_b_i;
  logic        done_o;
  logic [63:0] result_o;

  bit [63:0]   pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned op_count[4];
  int unsigned wide_pow_count;

  goldilocks_field_alu_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit [63:0] field_add(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] s0, s1, c0, c1;
    a  = a % FieldP;
    b  = b % FieldP;
    s0 = a + b;
    c0 = (s0 < a) ? FoldEps : 64'd0;
    s1 = s0 + c0;
    c1 = (s1 < s0) ? FoldEps : 64'd0;
    return s1 + c1;
  endfunction

  function automatic bit [63:0] field_sub(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] d0, d1, k0, k1;
    a  = a % FieldP;
    b  = b % FieldP;
    d0 = a - b;
    k0 = (a < b) ? FoldEps : 64'd0;
    d1 = d0 - k0;
    k1 = (d0 < k0) ? FoldEps : 64'd0;
    return d1 + k1;
  endfunction

  // fold the 128-bit product with 2^64 = 2^32 - 1 and 2^96 = -1
  function automatic bit [63:0] field_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] prod;
    bit [63:0]  lo, hi, hlo, hhi, r0, t1, r1, k;
    a    = a % FieldP;
    b    = b % FieldP;
    prod = {64'd0, a} * {64'd0, b};
    lo   = prod[63:0];
    hi   = prod[127:64];
    hlo  = hi & FoldEps;
    hhi  = hi >> 32;
    r0   = lo - hhi;
    if (lo < hhi) begin
      r0 = r0 - FoldEps;
    end
    t1 = (hlo << 32) - hlo;
    r1 = r0 + t1;
    k  = (r1 < r0) ? FoldEps : 64'd0;
    return r1 + k;
  endfunction

  // square-and-multiply from exponent bit 1 upwards
  function automatic bit [63:0] field_pow(input bit [63:0] base, input bit [63:0] e);
    bit [63:0] acc;
    base = base % FieldP;
    if (e == 64'd0) begin
      return 64'd1;
    end
    if (base == 64'd0) begin
      return 64'd0;
    end
    acc = e[0] ? base : 64'd1;
    for (int i = 1; i < 64; i++) begin
      if ((e >> i) == 64'd0) begin
        break;
      end
      base = field_mul(base, base);
      if (e[i]) begin
        acc = field_mul(acc, base);
      end
    end
    return acc;
  endfunction

  function automatic bit [63:0] predict_result(input glf_pkg::req_type_e op,
                                               input bit [63:0] a, input bit [63:0] b);
    case (op)
      glf_pkg::REQ_ADD: return field_add(a, b);
      glf_pkg::REQ_SUB: return field_sub(a, b);
      glf_pkg::REQ_MUL: return field_mul(a, b);
      default:          return field_pow(a, b);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic bit [63:0] rand_operand();
    bit [63:0] delta;
    delta = 64'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return FieldP - delta;
      1: return FieldP + delta;
      2: return AllOnes - delta;
      3: return delta;
      4: return {($urandom_range(0, 1) ? 32'hffff_ffff : 32'd0),
                 ($urandom_range(0, 1) ? 32'hffff_ffff : 32'd0)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly short exponents keep the run short; a tenth reach the full width
  function automatic bit [63:0] rand_exponent(output bit wide);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    wide = (pick < 10);
    if (pick < 10) begin
      return {$urandom, $urandom};
    end else if (pick < 30) begin
      return {32'd0, $urandom};
    end else if (pick < 36) begin
      return 64'($urandom_range(0, 1));
    end else begin
      return 64'($urandom_range(0, 16'hffff));
    end
  endfunction

  // hold start high until the item is taken, then idle for a gap between bursts
  task automatic send_item(input glf_pkg::req_type_e op, input bit [63:0] a,
                           input bit [63:0] b);
    int unsigned gap;
    req_type_i  <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    start       <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    pending_results.push_back(predict_result(op, a, b));
    op_count[op]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap   = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 8);
    end
  endtask

  task automatic test_add_sub_edges();
    send_item(glf_pkg::REQ_ADD, AllOnes, AllOnes);
    send_item(glf_pkg::REQ_ADD, FieldP - 1, FieldP - 1);
    send_item(glf_pkg::REQ_ADD, FieldP, 64'd0);
    send_item(glf_pkg::REQ_ADD, FieldP - 1, 64'd1);
    send_item(glf_pkg::REQ_ADD, 64'd0, 64'd0);
    send_item(glf_pkg::REQ_SUB, 64'd0, 64'd1);
    send_item(glf_pkg::REQ_SUB, 64'd0, FieldP - 1);
    send_item(glf_pkg::REQ_SUB, AllOnes, 64'd0);
    send_item(glf_pkg::REQ_SUB, FieldP, AllOnes);
  endtask

  task automatic test_mul_edges();
    send_item(glf_pkg::REQ_MUL, FieldP - 1, FieldP - 1);
    send_item(glf_pkg::REQ_MUL, AllOnes, AllOnes);
    send_item(glf_pkg::REQ_MUL, 64'd0, AllOnes);
    send_item(glf_pkg::REQ_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_item(glf_pkg::REQ_MUL, 64'h1_0000_0000_0000, 64'h1_0000_0000_0000);
    send_item(glf_pkg::REQ_MUL, FieldP, 64'd7);
  endtask

  task automatic test_pow_edges();
    send_item(glf_pkg::REQ_POW, 64'd5, 64'd0);
    send_item(glf_pkg::REQ_POW, 64'd0, 64'd7);
    send_item(glf_pkg::REQ_POW, FieldP, 64'd3);
    send_item(glf_pkg::REQ_POW, 64'd3, 64'd1);
    send_item(glf_pkg::REQ_POW, FieldP - 1, 64'd2);
    send_item(glf_pkg::REQ_POW, 64'd2, 64'h8000_0000_0000_0000);
    send_item(glf_pkg::REQ_POW, AllOnes, AllOnes);
    wide_pow_count += 2;
  endtask

  task automatic test_random_items();
    glf_pkg::req_type_e op;
    bit [63:0] a, b;
    bit        wide;
    for (int n = 0; n < RandomItems; n++) begin
      op   = glf_pkg::req_type_e'($urandom_range(0, 3));
      a    = rand_operand();
      wide = 1'b0;
      b    = (op == glf_pkg::REQ_POW) ? rand_exponent(wide) : rand_operand();
      if (wide) begin
        wide_pow_count++;
      end
      send_item(op, a, b);
    end
    start <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, result_o);
        error_count++;
      end else if (result_o !== pending_results[0]) begin
        $display("%0t: result mismatch: expected %h, actual %h", $time,
                 pending_results[0], result_o);
        error_count++;
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("goldilocks_field_alu_unit: mismatch");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = glf_pkg::REQ_ADD;
    operand_a_i = 64'd0;
    operand_b_i = 64'd0;
    error_count = 0;
    cycle_count = 0;
    burst_left  = 0;
    wide_pow_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_sub_edges();
    test_mul_edges();
    test_pow_edges();
    test_random_items();

    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d add, %0d sub, %0d mul and %0d pow items,",
             op_count[glf_pkg::REQ_ADD], op_count[glf_pkg::REQ_SUB],
             op_count[glf_pkg::REQ_MUL], op_count[glf_pkg::REQ_POW]);
    $display("%0d pow items with full-width exponents, %0d errors.",
             wide_pow_count, error_count);
    if (error_count == 0) begin
      $display("goldilocks_field_alu_unit: match");
    end else begin
      $display("goldilocks_field_alu_unit: mismatch");
    end
    $finish;
  end

endmodule
